FILE: hw/rtl/mbrs_pkg.sv
// ----------------------------------------------------------------------------
// mbrs_pkg
// Shared types, codes, constants and the CRC-16 byte update used by the
// Modbus RTU slave engine.
// ----------------------------------------------------------------------------
package mbrs_pkg;

    localparam int REG_COUNT_DEFAULT   = 64;
    localparam int FRAME_BYTES_DEFAULT = 256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [15:0] MAX_READ_REGS  = 16'd125;
    localparam logic [15:0] MAX_WRITE_REGS = 16'd123;
    localparam logic [15:0] LEN_SINGLE     = 16'd8;
    localparam logic [15:0] LEN_MULTI_MIN  = 16'd11;
    localparam logic [15:0] LEN_MULTI_OVH  = 16'd9;
    localparam logic [7:0]  EXC_FLAG       = 8'h80;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_GAP   = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    localparam logic [7:0] FC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FC_READ_INPUT   = 8'd4;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

    localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'd1;
    localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'd2;
    localparam logic [7:0] EXC_ILLEGAL_DATA = 8'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOCAL_RD,
        S_SCAN,
        S_CHECK,
        S_WMULT,
        S_RESP_HDR,
        S_RD_ISSUE,
        S_RD_HI,
        S_RD_LO,
        S_CRC_LO,
        S_CRC_HI,
        S_STATUS
    } mbrs_state_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  byte_data;
        logic        byte_last;
        logic        stat_valid;
        logic [15:0] stat_rd;
        logic        stat_ok;
    } mbrs_push_t;

    typedef struct packed {
        logic byte_ready;
        logic stat_ready;
    } mbrs_grant_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/mbrs_frame_ram.sv
// ----------------------------------------------------------------------------
// mbrs_frame_ram
// Receive frame buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbrs_frame_ram #(
    parameter int FRAME_BYTES = mbrs_pkg::FRAME_BYTES_DEFAULT,
    parameter int LEN_W       = $clog2(FRAME_BYTES)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [LEN_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             rd_en,
    input  logic [LEN_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [FRAME_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/mbrs_reg_ram.sv
// ----------------------------------------------------------------------------
// mbrs_reg_ram
// Holding register file: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbrs_reg_ram #(
    parameter int REG_COUNT = mbrs_pkg::REG_COUNT_DEFAULT,
    parameter int RA_W      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [RA_W-1:0] wr_addr,
    input  logic [15:0]     wr_data,
    input  logic            rd_en,
    input  logic [RA_W-1:0] rd_addr,
    output logic [15:0]     rd_data
);

    logic [15:0] mem [REG_COUNT];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/mbrs_tx_pack.sv
// ----------------------------------------------------------------------------
// mbrs_tx_pack
// Packs response bytes into chunks of up to four bytes, passes status items, and holds the result register.
// ----------------------------------------------------------------------------
module mbrs_tx_pack (
    input  logic                clk,
    input  logic                rst_n,
    input  mbrs_pkg::mbrs_push_t push,
    output mbrs_pkg::mbrs_grant_t grant,
    input  logic [31:0]         req_cnt,
    input  logic [31:0]         err_cnt,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         tx_bytes,
    output logic [2:0]          tx_count,
    output logic                tx_last,
    output logic [15:0]         read_data,
    output logic                local_ok,
    output logic [31:0]         request_count,
    output logic [31:0]         error_count
);

    logic        out_valid_reg, out_valid_next;
    logic [31:0] pk_word_reg, pk_word_next;
    logic [1:0]  pk_cnt_reg, pk_cnt_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [2:0]  count_reg, count_next;
    logic        last_reg, last_next;
    logic [15:0] rd_reg, rd_next;
    logic        ok_reg, ok_next;
    logic [31:0] req_reg, req_next;
    logic [31:0] err_reg, err_next;
    logic        out_free;
    logic [31:0] word;

    assign out_free = !out_valid_reg || out_ready;
    assign grant.byte_ready = out_free || (!push.byte_last && (pk_cnt_reg != 2'd3));
    assign grant.stat_ready = out_free;
    assign word = pk_word_reg | ({push.byte_data, 24'h000000} >> {pk_cnt_reg, 3'b000});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pk_word_next   = pk_word_reg;
        pk_cnt_next    = pk_cnt_reg;
        bytes_next     = bytes_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        rd_next        = rd_reg;
        ok_next        = ok_reg;
        req_next       = req_reg;
        err_next       = err_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (push.byte_valid && grant.byte_ready)
        begin
            if (push.byte_last || (pk_cnt_reg == 2'd3))
            begin
                out_valid_next = 1'b1;
                bytes_next     = word;
                count_next     = {1'b0, pk_cnt_reg} + 3'd1;
                last_next      = push.byte_last;
                rd_next        = 16'h0000;
                ok_next        = 1'b0;
                req_next       = req_cnt;
                err_next       = err_cnt;
                pk_word_next   = 32'h00000000;
                pk_cnt_next    = 2'd0;
            end
            else
            begin
                pk_word_next = word;
                pk_cnt_next  = pk_cnt_reg + 2'd1;
            end
        end
        else if (push.stat_valid && out_free)
        begin
            out_valid_next = 1'b1;
            bytes_next     = 32'h00000000;
            count_next     = 3'd0;
            last_next      = 1'b1;
            rd_next        = push.stat_rd;
            ok_next        = push.stat_ok;
            req_next       = req_cnt;
            err_next       = err_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pk_word_reg   <= 32'h00000000;
            pk_cnt_reg    <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pk_word_reg   <= pk_word_next;
            pk_cnt_reg    <= pk_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        count_reg <= count_next;
        last_reg  <= last_next;
        rd_reg    <= rd_next;
        ok_reg    <= ok_next;
        req_reg   <= req_next;
        err_reg   <= err_next;
    end

    assign out_valid     = out_valid_reg;
    assign tx_bytes      = bytes_reg;
    assign tx_count      = count_reg;
    assign tx_last       = last_reg;
    assign read_data     = rd_reg;
    assign local_ok      = ok_reg;
    assign request_count = req_reg;
    assign error_count   = err_reg;

endmodule

FILE: hw/rtl/mbrs_ctrl.sv
// ----------------------------------------------------------------------------
// mbrs_ctrl
// Sequencer: collects bytes, checks and dispatches frames, walks the frame
// buffer and register file, and feeds response bytes to the packer.
// ----------------------------------------------------------------------------
module mbrs_ctrl #(
    parameter int REG_COUNT   = mbrs_pkg::REG_COUNT_DEFAULT,
    parameter int FRAME_BYTES = mbrs_pkg::FRAME_BYTES_DEFAULT,
    parameter int LEN_W       = $clog2(FRAME_BYTES),
    parameter int RA_W        = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    input  logic [7:0]           rx_byte,
    input  logic [15:0]          local_addr,
    input  logic [15:0]          local_value,
    output logic                 fr_wr_en,
    output logic [LEN_W-1:0]     fr_wr_addr,
    output logic [7:0]           fr_wr_data,
    output logic                 fr_rd_en,
    output logic [LEN_W-1:0]     fr_rd_addr,
    input  logic [7:0]           fr_rd_data,
    output logic                 rg_wr_en,
    output logic [RA_W-1:0]      rg_wr_addr,
    output logic [15:0]          rg_wr_data,
    output logic                 rg_rd_en,
    output logic [RA_W-1:0]      rg_rd_addr,
    input  logic [15:0]          rg_rd_data,
    output mbrs_pkg::mbrs_push_t push,
    input  mbrs_pkg::mbrs_grant_t grant,
    output logic [31:0]          req_cnt,
    output logic [31:0]          err_cnt
);

    localparam logic [16:0] REG_LIMIT = 17'(REG_COUNT);

    mbrs_pkg::mbrs_state_t state_reg, state_next;
    logic [7:0]       sa_reg, sa_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0]      req_reg, req_next;
    logic [31:0]      err_reg, err_next;
    logic [RA_W-1:0]  clr_idx_reg, clr_idx_next;
    logic             scan_on_reg, scan_on_next;
    logic             pend_reg, pend_next;
    logic [LEN_W-1:0] scan_idx_reg, scan_idx_next;
    logic [LEN_W-1:0] scan_end_reg, scan_end_next;
    logic [LEN_W-1:0] pend_idx_reg, pend_idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      tcrc_reg, tcrc_next;
    logic [7:0]       fcrc_lo_reg, fcrc_lo_next;
    logic [7:0]       fcrc_hi_reg, fcrc_hi_next;
    logic [7:0]       hdr_reg [7];
    logic [7:0]       hdr_next [7];
    logic [7:0]       resp_reg [6];
    logic [7:0]       resp_next [6];
    logic [2:0]       resp_n_reg, resp_n_next;
    logic [2:0]       hidx_reg, hidx_next;
    logic             bcast_reg, bcast_next;
    logic             rdok_reg, rdok_next;
    logic [RA_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [6:0]       rd_cnt_reg, rd_cnt_next;
    logic [RA_W-1:0]  wr_addr_reg, wr_addr_next;
    logic [7:0]       hi_reg, hi_next;
    logic [15:0]      stat_rd_reg, stat_rd_next;
    logic             stat_ok_reg, stat_ok_next;

    logic        local_in_range;
    logic [15:0] start_w;
    logic [15:0] num_w;
    logic [15:0] flen;
    logic        crc_ok;
    logic        addr_hit;
    logic        in_span;
    logic        exc;
    logic [7:0]  exc_code;
    logic        go_wm;
    logic        go_rd;

    assign cfg_ready      = 1'b1;
    assign local_in_range = {1'b0, local_addr} < REG_LIMIT;
    assign start_w        = {hdr_reg[2], hdr_reg[3]};
    assign num_w          = {hdr_reg[4], hdr_reg[5]};
    assign flen           = 16'(len_reg);
    assign crc_ok         = {fcrc_hi_reg, fcrc_lo_reg} == crc_reg;
    assign addr_hit       = (hdr_reg[0] == sa_reg) || (hdr_reg[0] == 8'h00);
    assign in_span        = ({1'b0, start_w} < REG_LIMIT)
                            && (({1'b0, start_w} + {1'b0, num_w}) <= REG_LIMIT);
    assign req_cnt        = req_reg;
    assign err_cnt        = err_reg;
    assign fr_wr_addr     = len_reg;
    assign fr_wr_data     = rx_byte;
    assign fr_rd_addr     = scan_idx_reg;

    always_comb
    begin
        exc      = 1'b0;
        exc_code = mbrs_pkg::EXC_ILLEGAL_FUNC;
        go_wm    = 1'b0;
        go_rd    = 1'b0;
        case (hdr_reg[1])
            mbrs_pkg::FC_READ_HOLDING, mbrs_pkg::FC_READ_INPUT:
            begin
                if (flen != mbrs_pkg::LEN_SINGLE)
                begin
                    exc      = 1'b1;
                    exc_code = mbrs_pkg::EXC_ILLEGAL_DATA;
                end
                else if ((num_w == 16'd0) || (num_w > mbrs_pkg::MAX_READ_REGS) || !in_span)
                begin
                    exc      = 1'b1;
                    exc_code = mbrs_pkg::EXC_ILLEGAL_ADDR;
                end
                else
                begin
                    go_rd = 1'b1;
                end
            end
            mbrs_pkg::FC_WRITE_SINGLE:
            begin
                if (flen != mbrs_pkg::LEN_SINGLE)
                begin
                    exc      = 1'b1;
                    exc_code = mbrs_pkg::EXC_ILLEGAL_DATA;
                end
                else if ({1'b0, start_w} >= REG_LIMIT)
                begin
                    exc      = 1'b1;
                    exc_code = mbrs_pkg::EXC_ILLEGAL_ADDR;
                end
            end
            mbrs_pkg::FC_WRITE_MULTI:
            begin
                if (flen < mbrs_pkg::LEN_MULTI_MIN)
                begin
                    exc      = 1'b1;
                    exc_code = mbrs_pkg::EXC_ILLEGAL_DATA;
                end
                else if ((num_w == 16'd0) || (num_w > mbrs_pkg::MAX_WRITE_REGS)
                         || ({8'h00, hdr_reg[6]} != {num_w[14:0], 1'b0}) || !in_span
                         || (flen != ({8'h00, hdr_reg[6]} + mbrs_pkg::LEN_MULTI_OVH)))
                begin
                    exc      = 1'b1;
                    exc_code = mbrs_pkg::EXC_ILLEGAL_ADDR;
                end
                else
                begin
                    go_wm = 1'b1;
                end
            end
            default:
            begin
                exc      = 1'b1;
                exc_code = mbrs_pkg::EXC_ILLEGAL_FUNC;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        sa_next       = sa_reg;
        len_next      = len_reg;
        req_next      = req_reg;
        err_next      = err_reg;
        clr_idx_next  = clr_idx_reg;
        scan_on_next  = scan_on_reg;
        scan_idx_next = scan_idx_reg;
        scan_end_next = scan_end_reg;
        pend_next     = 1'b0;
        pend_idx_next = scan_idx_reg;
        crc_next      = crc_reg;
        tcrc_next     = tcrc_reg;
        fcrc_lo_next  = fcrc_lo_reg;
        fcrc_hi_next  = fcrc_hi_reg;
        hdr_next      = hdr_reg;
        resp_next     = resp_reg;
        resp_n_next   = resp_n_reg;
        hidx_next     = hidx_reg;
        bcast_next    = bcast_reg;
        rdok_next     = rdok_reg;
        rd_addr_next  = rd_addr_reg;
        rd_cnt_next   = rd_cnt_reg;
        wr_addr_next  = wr_addr_reg;
        hi_next       = hi_reg;
        stat_rd_next  = stat_rd_reg;
        stat_ok_next  = stat_ok_reg;
        in_ready      = (state_reg == mbrs_pkg::S_IDLE);
        fr_wr_en      = 1'b0;
        fr_rd_en      = 1'b0;
        rg_wr_en      = 1'b0;
        rg_wr_addr    = wr_addr_reg;
        rg_wr_data    = 16'h0000;
        rg_rd_en      = 1'b0;
        rg_rd_addr    = rd_addr_reg;
        push          = '0;

        if (cfg_valid)
        begin
            sa_next = cfg_data;
        end

        if (((state_reg == mbrs_pkg::S_SCAN) || (state_reg == mbrs_pkg::S_WMULT)) && scan_on_reg)
        begin
            fr_rd_en      = 1'b1;
            pend_next     = 1'b1;
            scan_idx_next = scan_idx_reg + LEN_W'(1);
            if (scan_idx_reg == scan_end_reg)
            begin
                scan_on_next = 1'b0;
            end
        end

        unique case (state_reg)
            mbrs_pkg::S_CLEAR:
            begin
                rg_wr_en   = 1'b1;
                rg_wr_addr = clr_idx_reg;
                if (clr_idx_reg == RA_W'(REG_COUNT - 1))
                begin
                    state_next = mbrs_pkg::S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + RA_W'(1);
                end
            end
            mbrs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode)
                        mbrs_pkg::MODE_BYTE:
                        begin
                            if (len_reg < LEN_W'(FRAME_BYTES - 1))
                            begin
                                fr_wr_en = 1'b1;
                                len_next = len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                len_next = '0;
                            end
                        end
                        mbrs_pkg::MODE_GAP:
                        begin
                            stat_rd_next = 16'h0000;
                            stat_ok_next = 1'b0;
                            if (len_reg == '0)
                            begin
                                state_next = mbrs_pkg::S_STATUS;
                            end
                            else if (len_reg < LEN_W'(4))
                            begin
                                err_next   = err_reg + 32'd1;
                                len_next   = '0;
                                state_next = mbrs_pkg::S_STATUS;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                scan_end_next = len_reg - LEN_W'(1);
                                scan_on_next  = 1'b1;
                                crc_next      = mbrs_pkg::CRC_INIT;
                                state_next    = mbrs_pkg::S_SCAN;
                            end
                        end
                        mbrs_pkg::MODE_WRITE:
                        begin
                            rg_wr_en     = local_in_range;
                            rg_wr_addr   = local_addr[RA_W-1:0];
                            rg_wr_data   = local_value;
                            stat_rd_next = 16'h0000;
                            stat_ok_next = local_in_range;
                            state_next   = mbrs_pkg::S_STATUS;
                        end
                        mbrs_pkg::MODE_READ:
                        begin
                            rg_rd_en     = local_in_range;
                            rg_rd_addr   = local_addr[RA_W-1:0];
                            stat_ok_next = local_in_range;
                            state_next   = mbrs_pkg::S_LOCAL_RD;
                        end
                        default:
                        begin
                            state_next = mbrs_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            mbrs_pkg::S_LOCAL_RD:
            begin
                stat_rd_next = stat_ok_reg ? rg_rd_data : 16'h0000;
                state_next   = mbrs_pkg::S_STATUS;
            end
            mbrs_pkg::S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (pend_idx_reg < LEN_W'(7))
                    begin
                        hdr_next[pend_idx_reg[2:0]] = fr_rd_data;
                    end
                    if (pend_idx_reg < (len_reg - LEN_W'(2)))
                    begin
                        crc_next = mbrs_pkg::crc16_byte(crc_reg, fr_rd_data);
                    end
                    if (pend_idx_reg == (len_reg - LEN_W'(2)))
                    begin
                        fcrc_lo_next = fr_rd_data;
                    end
                    if (pend_idx_reg == scan_end_reg)
                    begin
                        fcrc_hi_next = fr_rd_data;
                        state_next   = mbrs_pkg::S_CHECK;
                    end
                end
            end
            mbrs_pkg::S_CHECK:
            begin
                len_next     = '0;
                stat_rd_next = 16'h0000;
                stat_ok_next = 1'b0;
                tcrc_next    = mbrs_pkg::CRC_INIT;
                hidx_next    = 3'd0;
                if (!crc_ok)
                begin
                    err_next   = err_reg + 32'd1;
                    state_next = mbrs_pkg::S_STATUS;
                end
                else if (!addr_hit)
                begin
                    state_next = mbrs_pkg::S_STATUS;
                end
                else
                begin
                    req_next     = req_reg + 32'd1;
                    bcast_next   = (hdr_reg[0] == 8'h00);
                    rdok_next    = go_rd;
                    resp_next[0] = sa_reg;
                    resp_next[1] = hdr_reg[1];
                    resp_next[2] = hdr_reg[2];
                    resp_next[3] = hdr_reg[3];
                    resp_next[4] = hdr_reg[4];
                    resp_next[5] = hdr_reg[5];
                    resp_n_next  = 3'd6;
                    rd_addr_next = start_w[RA_W-1:0];
                    rd_cnt_next  = num_w[6:0];
                    wr_addr_next = start_w[RA_W-1:0];
                    if (exc)
                    begin
                        resp_next[1] = hdr_reg[1] | mbrs_pkg::EXC_FLAG;
                        resp_next[2] = exc_code;
                        resp_n_next  = 3'd3;
                        if (exc_code == mbrs_pkg::EXC_ILLEGAL_FUNC)
                        begin
                            err_next = err_reg + 32'd1;
                        end
                    end
                    else if (go_rd)
                    begin
                        resp_next[2] = {num_w[6:0], 1'b0};
                        resp_n_next  = 3'd3;
                    end
                    else if (!go_wm)
                    begin
                        rg_wr_en     = 1'b1;
                        rg_wr_addr   = start_w[RA_W-1:0];
                        rg_wr_data   = num_w;
                        resp_next[0] = hdr_reg[0];
                    end
                    if (go_wm)
                    begin
                        scan_idx_next = LEN_W'(7);
                        scan_end_next = len_reg - LEN_W'(3);
                        scan_on_next  = 1'b1;
                        state_next    = mbrs_pkg::S_WMULT;
                    end
                    else if (hdr_reg[0] == 8'h00)
                    begin
                        state_next = mbrs_pkg::S_STATUS;
                    end
                    else
                    begin
                        state_next = mbrs_pkg::S_RESP_HDR;
                    end
                end
            end
            mbrs_pkg::S_WMULT:
            begin
                if (pend_reg)
                begin
                    if (pend_idx_reg[0])
                    begin
                        hi_next = fr_rd_data;
                    end
                    else
                    begin
                        rg_wr_en     = 1'b1;
                        rg_wr_addr   = wr_addr_reg;
                        rg_wr_data   = {hi_reg, fr_rd_data};
                        wr_addr_next = wr_addr_reg + RA_W'(1);
                    end
                    if (pend_idx_reg == scan_end_reg)
                    begin
                        state_next = bcast_reg ? mbrs_pkg::S_STATUS : mbrs_pkg::S_RESP_HDR;
                    end
                end
            end
            mbrs_pkg::S_RESP_HDR:
            begin
                push.byte_valid = 1'b1;
                push.byte_data  = resp_reg[hidx_reg];
                if (grant.byte_ready)
                begin
                    tcrc_next = mbrs_pkg::crc16_byte(tcrc_reg, resp_reg[hidx_reg]);
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg == (resp_n_reg - 3'd1))
                    begin
                        state_next = rdok_reg ? mbrs_pkg::S_RD_ISSUE : mbrs_pkg::S_CRC_LO;
                    end
                end
            end
            mbrs_pkg::S_RD_ISSUE:
            begin
                rg_rd_en     = 1'b1;
                rd_addr_next = rd_addr_reg + RA_W'(1);
                state_next   = mbrs_pkg::S_RD_HI;
            end
            mbrs_pkg::S_RD_HI:
            begin
                push.byte_valid = 1'b1;
                push.byte_data  = rg_rd_data[15:8];
                if (grant.byte_ready)
                begin
                    tcrc_next  = mbrs_pkg::crc16_byte(tcrc_reg, rg_rd_data[15:8]);
                    state_next = mbrs_pkg::S_RD_LO;
                end
            end
            mbrs_pkg::S_RD_LO:
            begin
                push.byte_valid = 1'b1;
                push.byte_data  = rg_rd_data[7:0];
                if (grant.byte_ready)
                begin
                    tcrc_next = mbrs_pkg::crc16_byte(tcrc_reg, rg_rd_data[7:0]);
                    if (rd_cnt_reg == 7'd1)
                    begin
                        state_next = mbrs_pkg::S_CRC_LO;
                    end
                    else
                    begin
                        rd_cnt_next  = rd_cnt_reg - 7'd1;
                        rg_rd_en     = 1'b1;
                        rd_addr_next = rd_addr_reg + RA_W'(1);
                        state_next   = mbrs_pkg::S_RD_HI;
                    end
                end
            end
            mbrs_pkg::S_CRC_LO:
            begin
                push.byte_valid = 1'b1;
                push.byte_data  = tcrc_reg[7:0];
                if (grant.byte_ready)
                begin
                    state_next = mbrs_pkg::S_CRC_HI;
                end
            end
            mbrs_pkg::S_CRC_HI:
            begin
                push.byte_valid = 1'b1;
                push.byte_data  = tcrc_reg[15:8];
                push.byte_last  = 1'b1;
                if (grant.byte_ready)
                begin
                    state_next = mbrs_pkg::S_IDLE;
                end
            end
            mbrs_pkg::S_STATUS:
            begin
                push.stat_valid = 1'b1;
                push.stat_rd    = stat_rd_reg;
                push.stat_ok    = stat_ok_reg;
                if (grant.stat_ready)
                begin
                    state_next = mbrs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mbrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mbrs_pkg::S_CLEAR;
            sa_reg      <= 8'd1;
            len_reg     <= '0;
            req_reg     <= 32'd0;
            err_reg     <= 32'd0;
            clr_idx_reg <= '0;
            scan_on_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sa_reg      <= sa_next;
            len_reg     <= len_next;
            req_reg     <= req_next;
            err_reg     <= err_next;
            clr_idx_reg <= clr_idx_next;
            scan_on_reg <= scan_on_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        scan_end_reg <= scan_end_next;
        pend_idx_reg <= pend_idx_next;
        crc_reg      <= crc_next;
        tcrc_reg     <= tcrc_next;
        fcrc_lo_reg  <= fcrc_lo_next;
        fcrc_hi_reg  <= fcrc_hi_next;
        hdr_reg      <= hdr_next;
        resp_reg     <= resp_next;
        resp_n_reg   <= resp_n_next;
        hidx_reg     <= hidx_next;
        bcast_reg    <= bcast_next;
        rdok_reg     <= rdok_next;
        rd_addr_reg  <= rd_addr_next;
        rd_cnt_reg   <= rd_cnt_next;
        wr_addr_reg  <= wr_addr_next;
        hi_reg       <= hi_next;
        stat_rd_reg  <= stat_rd_next;
        stat_ok_reg  <= stat_ok_next;
    end

endmodule

FILE: hw/rtl/modbus_rtu_slave_engine.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_engine
// Modbus RTU slave with frame buffer, holding register file and chunked
// response output.
// ----------------------------------------------------------------------------
// A received byte gives no result. A frame gap walks the frame buffer one
// byte per cycle through its single read port; a write-multiple request then
// walks the data bytes again at one byte per cycle. Response bytes leave at
// one byte per cycle into a four-byte result register, one read of the
// register file per register returned, and stall only while the output side
// holds a finished result. A local write updates the register file and then
// reports its status; a local read reads the register file, then reports the
// value. After reset a clearing pass zeroes the register file, during which
// no item is accepted; configuration writes are taken at any time.
module modbus_rtu_slave_engine #(
    parameter int REG_COUNT   = mbrs_pkg::REG_COUNT_DEFAULT,
    parameter int FRAME_BYTES = mbrs_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] local_addr,
    input  logic [15:0] local_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] tx_bytes,
    output logic [2:0]  tx_count,
    output logic        tx_last,
    output logic [15:0] read_data,
    output logic        local_ok,
    output logic [31:0] request_count,
    output logic [31:0] error_count
);

    localparam int LEN_W = $clog2(FRAME_BYTES);
    localparam int RA_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic             fr_wr_en;
    logic [LEN_W-1:0] fr_wr_addr;
    logic [7:0]       fr_wr_data;
    logic             fr_rd_en;
    logic [LEN_W-1:0] fr_rd_addr;
    logic [7:0]       fr_rd_data;
    logic             rg_wr_en;
    logic [RA_W-1:0]  rg_wr_addr;
    logic [15:0]      rg_wr_data;
    logic             rg_rd_en;
    logic [RA_W-1:0]  rg_rd_addr;
    logic [15:0]      rg_rd_data;
    logic [31:0]      req_cnt;
    logic [31:0]      err_cnt;

    mbrs_pkg::mbrs_push_t  push;
    mbrs_pkg::mbrs_grant_t grant;

    mbrs_ctrl #(
        .REG_COUNT   (REG_COUNT),
        .FRAME_BYTES (FRAME_BYTES),
        .LEN_W       (LEN_W),
        .RA_W        (RA_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .rx_byte     (rx_byte),
        .local_addr  (local_addr),
        .local_value (local_value),
        .fr_wr_en    (fr_wr_en),
        .fr_wr_addr  (fr_wr_addr),
        .fr_wr_data  (fr_wr_data),
        .fr_rd_en    (fr_rd_en),
        .fr_rd_addr  (fr_rd_addr),
        .fr_rd_data  (fr_rd_data),
        .rg_wr_en    (rg_wr_en),
        .rg_wr_addr  (rg_wr_addr),
        .rg_wr_data  (rg_wr_data),
        .rg_rd_en    (rg_rd_en),
        .rg_rd_addr  (rg_rd_addr),
        .rg_rd_data  (rg_rd_data),
        .push        (push),
        .grant       (grant),
        .req_cnt     (req_cnt),
        .err_cnt     (err_cnt)
    );

    mbrs_frame_ram #(
        .FRAME_BYTES (FRAME_BYTES),
        .LEN_W       (LEN_W)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (fr_wr_en),
        .wr_addr (fr_wr_addr),
        .wr_data (fr_wr_data),
        .rd_en   (fr_rd_en),
        .rd_addr (fr_rd_addr),
        .rd_data (fr_rd_data)
    );

    mbrs_reg_ram #(
        .REG_COUNT (REG_COUNT),
        .RA_W      (RA_W)
    ) u_reg_ram (
        .clk     (clk),
        .wr_en   (rg_wr_en),
        .wr_addr (rg_wr_addr),
        .wr_data (rg_wr_data),
        .rd_en   (rg_rd_en),
        .rd_addr (rg_rd_addr),
        .rd_data (rg_rd_data)
    );

    mbrs_tx_pack u_tx_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .grant         (grant),
        .req_cnt       (req_cnt),
        .err_cnt       (err_cnt),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_bytes      (tx_bytes),
        .tx_count      (tx_count),
        .tx_last       (tx_last),
        .read_data     (read_data),
        .local_ok      (local_ok),
        .request_count (request_count),
        .error_count   (error_count)
    );

endmodule

FILE: tb/sv/mbrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrs_checker
// Watches the configuration, request and response channels of the Modbus
// RTU slave engine, keeps its own copy of the register file, frame buffer
// and counters, predicts every response item and compares field by field.
// ----------------------------------------------------------------------------
package mbrs_tb_util;

    function automatic logic [15:0] crc_of(input logic [7:0] bytes[$]);
        logic [15:0] c;
        c = mbrs_pkg::CRC_INIT;
        foreach (bytes[i])
        begin
            c ^= {8'h00, bytes[i]};
            for (int b = 0; b < 8; b++)
                c = c[0] ? ((c >> 1) ^ mbrs_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

module mbrs_checker
    import mbrs_pkg::*;
    import mbrs_tb_util::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] local_addr,
    input  logic [15:0] local_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] tx_bytes,
    input  logic [2:0]  tx_count,
    input  logic        tx_last,
    input  logic [15:0] read_data,
    input  logic        local_ok,
    input  logic [31:0] request_count,
    input  logic [31:0] error_count,
    output int          fails,
    output int          pending,
    output int          checked
);

    typedef struct {
        logic [31:0] bytes;
        logic [2:0]  cnt;
        logic        last;
        logic [15:0] rd;
        logic        ok;
        logic [31:0] req;
        logic [31:0] err;
    } reply_t;

    reply_t      replies_due[$];
    logic [15:0] hregs [REG_COUNT_DEFAULT];
    logic [7:0]  fbuf [FRAME_BYTES_DEFAULT];
    int unsigned flen;
    logic [31:0] reqs;
    logic [31:0] errs;
    logic [7:0]  station;

    initial
    begin
        foreach (hregs[i]) hregs[i] = 16'h0000;
        flen = 0;
        reqs = 0;
        errs = 0;
        station = 8'd1;
        fails = 0;
        pending = 0;
        checked = 0;
    end

    task automatic push_reply(input logic [31:0] bytes, input logic [2:0] cnt,
                              input logic last, input logic [15:0] rd, input logic ok);
        reply_t r;
        r.bytes = bytes;
        r.cnt = cnt;
        r.last = last;
        r.rd = rd;
        r.ok = ok;
        r.req = reqs;
        r.err = errs;
        replies_due.push_back(r);
    endtask

    function automatic int unsigned be16(input int unsigned i);
        return {fbuf[i], fbuf[i + 1]};
    endfunction

    task automatic handle_gap();
        logic [7:0]  resp[$];
        logic [7:0]  body[$];
        logic [7:0]  fc;
        logic [15:0] c;
        logic [31:0] w;
        int unsigned start, num, bc, pos, n;
        resp = {};
        if (flen > 0)
        begin
            if (flen < 4)
                errs++;
            else
            begin
                for (int unsigned i = 0; i < flen - 2; i++) body.push_back(fbuf[i]);
                if ({fbuf[flen - 1], fbuf[flen - 2]} != crc_of(body))
                    errs++;
                else if (fbuf[0] == station || fbuf[0] == 8'h00)
                begin
                    fc = fbuf[1];
                    if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT)
                    begin
                        if (flen != LEN_SINGLE)
                            resp = {station, fc | EXC_FLAG, EXC_ILLEGAL_DATA};
                        else
                        begin
                            start = be16(2);
                            num = be16(4);
                            if (num == 0 || num > MAX_READ_REGS || start >= REG_COUNT_DEFAULT
                                || start + num > REG_COUNT_DEFAULT)
                                resp = {station, fc | EXC_FLAG, EXC_ILLEGAL_ADDR};
                            else
                            begin
                                resp = {station, fc, 8'(num * 2)};
                                for (int unsigned i = 0; i < num; i++)
                                begin
                                    resp.push_back(hregs[start + i][15:8]);
                                    resp.push_back(hregs[start + i][7:0]);
                                end
                            end
                        end
                    end
                    else if (fc == FC_WRITE_SINGLE)
                    begin
                        if (flen != LEN_SINGLE)
                            resp = {station, fc | EXC_FLAG, EXC_ILLEGAL_DATA};
                        else
                        begin
                            start = be16(2);
                            if (start >= REG_COUNT_DEFAULT)
                                resp = {station, fc | EXC_FLAG, EXC_ILLEGAL_ADDR};
                            else
                            begin
                                hregs[start] = 16'(be16(4));
                                for (int i = 0; i < 6; i++) resp.push_back(fbuf[i]);
                            end
                        end
                    end
                    else if (fc == FC_WRITE_MULTI)
                    begin
                        if (flen < LEN_MULTI_MIN)
                            resp = {station, fc | EXC_FLAG, EXC_ILLEGAL_DATA};
                        else
                        begin
                            start = be16(2);
                            num = be16(4);
                            bc = fbuf[6];
                            if (num == 0 || num > MAX_WRITE_REGS || bc != num * 2
                                || start >= REG_COUNT_DEFAULT || start + num > REG_COUNT_DEFAULT
                                || flen != LEN_MULTI_OVH + bc)
                                resp = {station, fc | EXC_FLAG, EXC_ILLEGAL_ADDR};
                            else
                            begin
                                for (int unsigned i = 0; i < num; i++)
                                    hregs[start + i] = 16'(be16(7 + 2 * i));
                                resp = {station, fc, 8'(start >> 8), 8'(start),
                                        8'(num >> 8), 8'(num)};
                            end
                        end
                    end
                    else
                    begin
                        resp = {station, fc | EXC_FLAG, EXC_ILLEGAL_FUNC};
                        errs++;
                    end
                    reqs++;
                    if (fbuf[0] == 8'h00)
                        resp = {};
                    else
                    begin
                        c = crc_of(resp);
                        resp.push_back(c[7:0]);
                        resp.push_back(c[15:8]);
                    end
                end
            end
        end
        flen = 0;
        if (resp.size() == 0)
            push_reply(32'h0, 3'd0, 1'b1, 16'h0, 1'b0);
        else
        begin
            pos = 0;
            while (pos < resp.size())
            begin
                n = (resp.size() - pos > 4) ? 4 : resp.size() - pos;
                w = 32'h0;
                for (int unsigned j = 0; j < 4; j++)
                    w = {w[23:0], (j < n) ? resp[pos + j] : 8'h00};
                pos += n;
                push_reply(w, 3'(n), pos >= resp.size(), 16'h0, 1'b0);
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("checker: %s mismatch, got %h expected %h", what, got, want);
        fails++;
    endtask

    always @(posedge clk)
    begin
        reply_t r;
        logic   ok;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (replies_due.size() == 0)
                    report("unexpected item", tx_bytes, 32'h0);
                else
                begin
                    r = replies_due.pop_front();
                    if (tx_bytes !== r.bytes) report("tx_bytes", tx_bytes, r.bytes);
                    if (tx_count !== r.cnt) report("tx_count", tx_count, r.cnt);
                    if (tx_last !== r.last) report("tx_last", tx_last, r.last);
                    if (read_data !== r.rd) report("read_data", read_data, r.rd);
                    if (local_ok !== r.ok) report("local_ok", local_ok, r.ok);
                    if (request_count !== r.req) report("request_count", request_count, r.req);
                    if (error_count !== r.err) report("error_count", error_count, r.err);
                end
            end
            if (cfg_valid && cfg_ready)
                station = cfg_data;
            if (in_valid && in_ready)
            begin
                ok = local_addr < REG_COUNT_DEFAULT;
                case (mode)
                    MODE_BYTE:
                    begin
                        if (flen < FRAME_BYTES_DEFAULT - 1)
                        begin
                            fbuf[flen] = rx_byte;
                            flen++;
                        end
                        else
                            flen = 0;
                    end
                    MODE_GAP: handle_gap();
                    MODE_WRITE:
                    begin
                        if (ok) hregs[local_addr] = local_value;
                        push_reply(32'h0, 3'd0, 1'b1, 16'h0, ok);
                    end
                    default: push_reply(32'h0, 3'd0, 1'b1, ok ? hregs[local_addr] : 16'h0, ok);
                endcase
            end
            pending = replies_due.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Modbus RTU slave engine: directed frames for
// the main function codes, exception and error cases, then random requests
// over several station addresses and idling phases, with one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import mbrs_pkg::*;
    import mbrs_tb_util::*;

    localparam int IDLE_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data = 8'd1;
    logic        in_valid = 1'b0;
    logic [1:0]  mode = MODE_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic [15:0] local_addr = 16'h0;
    logic [15:0] local_value = 16'h0;
    logic        out_ready = 1'b0;
    logic        hold = 1'b0;
    logic        cfg_ready, in_ready, out_valid, tx_last, local_ok;
    logic [31:0] tx_bytes, request_count, error_count;
    logic [2:0]  tx_count;
    logic [15:0] read_data;
    int          fails, pending, checked;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          items = 0;
    int          quiet_cycles = 0;

    modbus_rtu_slave_engine uut (.*);

    mbrs_checker u_checker (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        out_ready <= !hold && ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == IDLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] m, input logic [7:0] b,
                             input logic [15:0] a, input logic [15:0] v);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        rx_byte <= b;
        local_addr <= a;
        local_value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(MODE_BYTE, b, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_gap();
        send_item(MODE_GAP, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic local_wr(input logic [15:0] a, input logic [15:0] v);
        send_item(MODE_WRITE, 8'($urandom), a, v);
    endtask

    task automatic local_rd(input logic [15:0] a);
        send_item(MODE_READ, 8'($urandom), a, 16'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] body[$], input bit corrupt);
        logic [15:0] c;
        c = crc_of(body);
        if (corrupt) c ^= 16'h0001 << $urandom_range(0, 15);
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i]) send_byte(body[i]);
        send_gap();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_station(input logic [7:0] s);
        cfg_valid <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic rand_request(input logic [7:0] s);
        int          r;
        logic [7:0]  fc;
        logic [7:0]  body[$];
        int unsigned start, num, bc, nbytes;
        r = $urandom_range(0, 99);
        start = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 66);
        if (r < 12)
            local_wr(16'(start), 16'($urandom));
        else if (r < 24)
            local_rd(16'(start));
        else if (r < 34)
        begin
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
            send_gap();
        end
        else
        begin
            r = $urandom_range(0, 99);
            body.push_back((r < 80) ? s : (r < 90) ? 8'h00 : 8'($urandom));
            case ($urandom_range(0, 4))
                0: fc = FC_READ_HOLDING;
                1: fc = FC_READ_INPUT;
                2: fc = FC_WRITE_SINGLE;
                3: fc = FC_WRITE_MULTI;
                default: fc = 8'($urandom);
            endcase
            num = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 130) : $urandom_range(1, 3);
            body.push_back(fc);
            body.push_back(8'(start >> 8));
            body.push_back(8'(start));
            if (fc == FC_WRITE_SINGLE)
            begin
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
            end
            else
            begin
                body.push_back(8'(num >> 8));
                body.push_back(8'(num));
                if (fc == FC_WRITE_MULTI)
                begin
                    bc = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : num * 2;
                    body.push_back(8'(bc));
                    nbytes = (num * 2 > 8) ? 8 : num * 2;
                    repeat (nbytes) body.push_back(8'($urandom));
                end
            end
            if ($urandom_range(0, 19) == 0) body.push_back(8'($urandom));
            else if ($urandom_range(0, 19) == 0) void'(body.pop_back());
            send_frame(body, $urandom_range(0, 14) == 0);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        local_wr(16'd63, 16'h1234);
        local_rd(16'd63);
        local_rd(16'hFFFF);
        send_gap();
        send_frame({8'd1, FC_READ_HOLDING, 8'd0, 8'd62, 8'd0, 8'd2}, 1'b0);
        send_frame({8'd1, FC_WRITE_SINGLE, 8'd0, 8'd5, 8'hAB, 8'hCD}, 1'b0);
        send_frame({8'd1, FC_WRITE_MULTI, 8'd0, 8'd10, 8'd0, 8'd1, 8'd2,
                    8'h12, 8'h34}, 1'b0);
        send_frame({8'd1, 8'h41}, 1'b0);
        send_frame({8'd1, 8'h41}, 1'b1);
        send_frame({8'd0, FC_WRITE_SINGLE, 8'd0, 8'd7, 8'h55, 8'hAA}, 1'b0);
        send_byte(8'd1);
        send_byte(FC_READ_HOLDING);
        send_gap();
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            logic [7:0] s;
            case (phase)
                0: begin s = 8'd247; idle_pct = 0;  stall_pct = 0;  end
                1: begin s = 8'd1;   idle_pct = 72; stall_pct = 0;  end
                2: begin s = 8'($urandom_range(2, 246)); idle_pct = 0; stall_pct = 72; end
                default: begin s = 8'($urandom_range(1, 247)); idle_pct = 38; stall_pct = 38; end
            endcase
            set_station(s);
            repeat (2) rand_request(s);
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold <= 1'b1;
                repeat (300) @(posedge clk);
                hold <= 1'b0;
            end
            repeat (8) local_rd(16'($urandom_range(0, 70)));
        join
        drain();

        $display("tb: %0d items over four station and idling phases plus a long output stall",
                 items);
        $display("tb: %0d response items compared, %0d mismatches, %0d never seen",
                 checked, fails, pending);
        if (fails == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
